// ===== design/tca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tca_pkg;

   // Width of one colour channel and of each mean.
   localparam int PIX_W = 8;

   // Default limit on counted pixels per tile.
   localparam int MAX_PIXELS_DEF = 65536;

   // The divider produces one quotient bit per step.
   localparam int Q_STEPS = PIX_W;
   localparam int STEP_W  = $clog2(Q_STEPS);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_RED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_GREEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_BLUE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ENABLE = 2'd3;

   // Register reset values: magenta key, keying on.
   localparam logic [PIX_W-1:0] KEY_RED_RST   = 8'd255;
   localparam logic [PIX_W-1:0] KEY_GREEN_RST = 8'd0;
   localparam logic [PIX_W-1:0] KEY_BLUE_RST  = 8'd255;
   localparam logic             KEY_EN_RST    = 1'b1;

   // Channel currently served by the shared divider.
   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } chan_type;

endpackage

`default_nettype wire

// ===== design/tca_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tca_req_if import tca_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             tile_end;

   modport source (output valid, output red, output green, output blue, output tile_end,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input tile_end,
                   output ready);
endinterface

interface tca_rsp_if import tca_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] mean_red;
   logic [PIX_W-1:0] mean_green;
   logic [PIX_W-1:0] mean_blue;
   logic             empty_res;

   modport source (output valid, output mean_red, output mean_green, output mean_blue,
                   output empty_res, input ready);
   modport sink   (input valid, input mean_red, input mean_green, input mean_blue,
                   input empty_res, output ready);
endinterface

interface tca_csr_if import tca_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [PIX_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tile_colour_average_keyed.sv =====
// Keyed colour average of one mosaic tile. Pixels stream in on req_if, the last
// pixel of a tile marked by tile_end; pixels equal to the key colour (magenta
// after reset) are skipped while keying is enabled, and at most MAX_PIXELS
// pixels per tile are summed. A pixel without tile_end leaves the block ready
// for the next pixel. A tile_end pixel starts the three mean divisions, red,
// green and blue in turn, on one shared divider that yields one quotient bit
// per cycle; a tile with no counted pixel skips them. No further pixel is
// taken until the means are loaded into the output register on rsp_if, where
// the result waits; a further tile_end pixel is finished only once that
// register is free. Configuration writes on csr_if are always taken.
`timescale 1ns / 1ps
`default_nettype none

module tile_colour_average_keyed import tca_pkg::*; #(
   parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tca_req_if.sink   req_if,
   tca_rsp_if.source rsp_if,
   tca_csr_if.sink   csr_if
);

   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W = CNT_W + PIX_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

   typedef enum logic [2:0] {
      ST_ACC  = 3'b001,
      ST_DIV  = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   chan_type         chan_ff, chan_in;
   logic             start_ff, start_in;
   logic [PIX_W-1:0] key_red_ff, key_green_ff, key_blue_ff;
   logic             key_en_ff;
   logic [SUM_W-1:0] sum_red_ff, sum_red_in;
   logic [SUM_W-1:0] sum_green_ff, sum_green_in;
   logic [SUM_W-1:0] sum_blue_ff, sum_blue_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PIX_W-1:0] mean_red_ff, mean_red_in;
   logic [PIX_W-1:0] mean_green_ff, mean_green_in;
   logic [PIX_W-1:0] mean_blue_ff, mean_blue_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_red_ff, rsp_red_in;
   logic [PIX_W-1:0] rsp_green_ff, rsp_green_in;
   logic [PIX_W-1:0] rsp_blue_ff, rsp_blue_in;
   logic             rsp_empty_ff, rsp_empty_in;

   logic             take;
   logic             keyed;
   logic             counted;
   logic [CNT_W-1:0] cnt_next;
   logic [SUM_W-1:0] dividend;
   logic             div_done;
   logic [PIX_W-1:0] quotient;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_red_ff   <= KEY_RED_RST;
         key_green_ff <= KEY_GREEN_RST;
         key_blue_ff  <= KEY_BLUE_RST;
         key_en_ff    <= KEY_EN_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_KEY_RED:    key_red_ff   <= csr_if.data;
            CSR_KEY_GREEN:  key_green_ff <= csr_if.data;
            CSR_KEY_BLUE:   key_blue_ff  <= csr_if.data;
            CSR_KEY_ENABLE: key_en_ff    <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_ACC);
   assign take         = req_if.valid && req_if.ready;
   assign keyed        = key_en_ff && (req_if.red == key_red_ff) &&
                         (req_if.green == key_green_ff) && (req_if.blue == key_blue_ff);
   assign counted      = !keyed && (cnt_ff < CNT_MAX);
   assign cnt_next     = counted ? cnt_ff + CNT_W'(1) : cnt_ff;

   always_comb begin
      case (chan_ff)
         CH_RED:   dividend = sum_red_ff;
         CH_GREEN: dividend = sum_green_ff;
         CH_BLUE:  dividend = sum_blue_ff;
         default:  dividend = '0;
      endcase
   end

   tca_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (dividend),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      start_in      = 1'b0;
      sum_red_in    = sum_red_ff;
      sum_green_in  = sum_green_ff;
      sum_blue_in   = sum_blue_ff;
      cnt_in        = cnt_ff;
      mean_red_in   = mean_red_ff;
      mean_green_in = mean_green_ff;
      mean_blue_in  = mean_blue_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_empty_in  = rsp_empty_ff;
      case (state_ff)
         ST_ACC: begin
            if (take) begin
               if (counted) begin
                  sum_red_in   = sum_red_ff + SUM_W'(req_if.red);
                  sum_green_in = sum_green_ff + SUM_W'(req_if.green);
                  sum_blue_in  = sum_blue_ff + SUM_W'(req_if.blue);
               end
               cnt_in = cnt_next;
               if (req_if.tile_end) begin
                  if (cnt_next == '0) begin
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_DIV;
                     chan_in  = CH_RED;
                     start_in = 1'b1;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               case (chan_ff)
                  CH_RED: begin
                     mean_red_in = quotient;
                     chan_in     = CH_GREEN;
                     start_in    = 1'b1;
                  end
                  CH_GREEN: begin
                     mean_green_in = quotient;
                     chan_in       = CH_BLUE;
                     start_in      = 1'b1;
                  end
                  default: begin
                     mean_blue_in = quotient;
                     state_in     = ST_LOAD;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            // Wait for the output register to drain, then hand over the means
            // and clear the accumulators for the next tile.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = (cnt_ff == '0);
               rsp_red_in   = (cnt_ff == '0) ? '0 : mean_red_ff;
               rsp_green_in = (cnt_ff == '0) ? '0 : mean_green_ff;
               rsp_blue_in  = (cnt_ff == '0) ? '0 : mean_blue_ff;
               sum_red_in   = '0;
               sum_green_in = '0;
               sum_blue_in  = '0;
               cnt_in       = '0;
               state_in     = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         chan_ff      <= CH_RED;
         start_ff     <= 1'b0;
         sum_red_ff   <= '0;
         sum_green_ff <= '0;
         sum_blue_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         start_ff     <= start_in;
         sum_red_ff   <= sum_red_in;
         sum_green_ff <= sum_green_in;
         sum_blue_ff  <= sum_blue_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_red_ff   <= mean_red_in;
      mean_green_ff <= mean_green_in;
      mean_blue_ff  <= mean_blue_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.mean_red   = rsp_red_ff;
   assign rsp_if.mean_green = rsp_green_ff;
   assign rsp_if.mean_blue  = rsp_blue_ff;
   assign rsp_if.empty_res  = rsp_empty_ff;

endmodule

`default_nettype wire

// ===== design/tca_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tca_div import tca_pkg::*; #(
   parameter int CNT_W = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [CNT_W+PIX_W-1:0] dividend,
   input  logic [CNT_W-1:0]       divisor,
   output logic                   done,
   output logic [PIX_W-1:0]       quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [PIX_W-1:0]  low_ff, low_in;
   logic [PIX_W-1:0]  q_ff, q_in;

   logic [CNT_W:0] trial;
   logic [CNT_W:0] diff;
   logic           fits;

   // The quotient is known to fit in PIX_W bits, so the upper dividend bits
   // start out as the partial remainder and only the low byte is shifted in.
   assign trial = {rem_ff, low_ff[PIX_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = !diff[CNT_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dividend[CNT_W+PIX_W-1:PIX_W];
         low_in  = dividend[PIX_W-1:0];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         low_in  = {low_ff[PIX_W-2:0], 1'b0};
         q_in    = {q_ff[PIX_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(Q_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// ===== design/tca_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tca_checker import tca_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             req_tile_end,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [PIX_W-1:0] rsp_mean_red,
   input wire logic [PIX_W-1:0] rsp_mean_green,
   input wire logic [PIX_W-1:0] rsp_mean_blue,
   input wire logic             rsp_empty_res
);

   // A result that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_red) &&
      $stable(rsp_mean_green) && $stable(rsp_mean_blue) && $stable(rsp_empty_res))
      else $error("result changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The last pixel of a tile always starts a busy period.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_tile_end |=> !req_ready)
      else $error("ready after the last pixel of a tile");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |->
      rsp_mean_red == '0 && rsp_mean_green == '0 && rsp_mean_blue == '0)
      else $error("empty tile with nonzero means");

   // A new result is only loaded while pixel input is held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while pixels were being taken");

endmodule

bind tile_colour_average_keyed tca_checker u_tca_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_tile_end   (req_if.tile_end),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_mean_red   (rsp_if.mean_red),
   .rsp_mean_green (rsp_if.mean_green),
   .rsp_mean_blue  (rsp_if.mean_blue),
   .rsp_empty_res  (rsp_if.empty_res)
);

`default_nettype wire

// ===== tb/tb_tile_colour_average_keyed.sv =====
`timescale 1ns / 1ps

module tb_tile_colour_average_keyed;
   import tca_pkg::*;

   typedef struct {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             tile_end;
   } pixel_t;

   typedef struct {
      logic [PIX_W-1:0] mean_red;
      logic [PIX_W-1:0] mean_green;
      logic [PIX_W-1:0] mean_blue;
      logic             empty_res;
   } tile_mean_t;

   logic clock = 1'b0;
   logic reset;

   tca_req_if req_if ();
   tca_rsp_if rsp_if ();
   tca_csr_if csr_if ();

   tile_colour_average_keyed dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pixel_t     pixel_queue[$];
   tile_mean_t mean_queue[$];

   // Shadow copy of the key registers, updated when a write transaction is taken.
   logic [PIX_W-1:0] key_red_q;
   logic [PIX_W-1:0] key_green_q;
   logic [PIX_W-1:0] key_blue_q;
   logic             key_en_q;

   // Running tile totals of the predictor.
   int unsigned sum_red_q;
   int unsigned sum_green_q;
   int unsigned sum_blue_q;
   int unsigned count_q;

   int   mismatch_count = 0;
   logic req_taken      = 1'b0;
   logic calm           = 1'b0;
   int   hold_request   = 0;
   int   hold_left      = 0;
   int   random_items   = 0;

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.red     = '0;
      req_if.green   = '0;
      req_if.blue    = '0;
      req_if.tile_end = 1'b0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_KEY_RED;
      csr_if.data    = '0;
      key_red_q      = KEY_RED_RST;
      key_green_q    = KEY_GREEN_RST;
      key_blue_q     = KEY_BLUE_RST;
      key_en_q       = KEY_EN_RST;
      sum_red_q      = 0;
      sum_green_q    = 0;
      sum_blue_q     = 0;
      count_q        = 0;
   end

   task automatic fold_pixel(input pixel_t px);
      tile_mean_t m;
      logic       keyed;
      keyed = key_en_q && px.red == key_red_q && px.green == key_green_q &&
              px.blue == key_blue_q;
      if (!keyed && count_q < MAX_PIXELS_DEF) begin
         sum_red_q   += px.red;
         sum_green_q += px.green;
         sum_blue_q  += px.blue;
         count_q++;
      end
      if (px.tile_end) begin
         if (count_q == 0) begin
            m.mean_red   = '0;
            m.mean_green = '0;
            m.mean_blue  = '0;
            m.empty_res  = 1'b1;
         end else begin
            m.mean_red   = PIX_W'(sum_red_q / count_q);
            m.mean_green = PIX_W'(sum_green_q / count_q);
            m.mean_blue  = PIX_W'(sum_blue_q / count_q);
            m.empty_res  = 1'b0;
         end
         mean_queue.push_back(m);
         sum_red_q   = 0;
         sum_green_q = 0;
         sum_blue_q  = 0;
         count_q     = 0;
      end
   endtask

   // Predictor and checker, sampling at the rising edge.
   always @(posedge clock) begin : monitor
      tile_mean_t want;
      pixel_t     px;
      logic       bad;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_KEY_RED:    key_red_q   = csr_if.data;
               CSR_KEY_GREEN:  key_green_q = csr_if.data;
               CSR_KEY_BLUE:   key_blue_q  = csr_if.data;
               CSR_KEY_ENABLE: key_en_q    = csr_if.data[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            px.red      = req_if.red;
            px.green    = req_if.green;
            px.blue     = req_if.blue;
            px.tile_end = req_if.tile_end;
            fold_pixel(px);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (mean_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result %0d/%0d/%0d empty=%0b", $realtime,
                           rsp_if.mean_red, rsp_if.mean_green, rsp_if.mean_blue,
                           rsp_if.empty_res);
            end else begin
               want = mean_queue.pop_front();
               bad  = 1'b0;
               if (rsp_if.mean_red !== want.mean_red) bad = 1'b1;
               if (rsp_if.mean_green !== want.mean_green) bad = 1'b1;
               if (rsp_if.mean_blue !== want.mean_blue) bad = 1'b1;
               if (rsp_if.empty_res !== want.empty_res) bad = 1'b1;
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch expected %0d/%0d/%0d empty=%0b, got %0d/%0d/%0d empty=%0b",
                              $realtime, want.mean_red, want.mean_green, want.mean_blue,
                              want.empty_res, rsp_if.mean_red, rsp_if.mean_green,
                              rsp_if.mean_blue, rsp_if.empty_res);
               end
            end
         end
      end
      req_taken <= req_if.valid && req_if.ready;
   end

   // Pixel driver: a new transaction may be offered at the falling edge once the
   // previous one has been taken; outside calm phases random gaps are inserted.
   always @(negedge clock) begin : driver
      pixel_t px;
      if (!reset && (!req_if.valid || req_taken)) begin
         if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
            px = pixel_queue.pop_front();
            req_if.valid    <= 1'b1;
            req_if.red      <= px.red;
            req_if.green    <= px.green;
            req_if.blue     <= px.blue;
            req_if.tile_end <= px.tile_end;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result receiver with random back-pressure and requested long hold-offs.
   always @(negedge clock) begin : receiver
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   task automatic write_key_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PIX_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_key(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                          input logic [PIX_W-1:0] b, input logic en);
      write_key_reg(CSR_KEY_RED, r);
      write_key_reg(CSR_KEY_GREEN, g);
      write_key_reg(CSR_KEY_BLUE, b);
      write_key_reg(CSR_KEY_ENABLE, {{(PIX_W-1){1'b0}}, en});
   endtask

   task automatic push_pixel(input int r, input int g, input int b, input logic last);
      pixel_t px;
      px.red      = PIX_W'(r);
      px.green    = PIX_W'(g);
      px.blue     = PIX_W'(b);
      px.tile_end = last;
      pixel_queue.push_back(px);
   endtask

   // Biased pixel: often the key colour or a near miss of it, else extremes
   // or random values.
   function automatic pixel_t random_pixel();
      pixel_t px;
      int     pick;
      pick = $urandom_range(99);
      px.red   = key_red_q;
      px.green = key_green_q;
      px.blue  = key_blue_q;
      if (pick < 25) begin
      end else if (pick < 35) begin
         px.red = '0; px.green = '0; px.blue = '0;
      end else if (pick < 45) begin
         px.red = '1; px.green = '1; px.blue = '1;
      end else if (pick < 60) begin
         case ($urandom_range(2))
            0: px.red   ^= PIX_W'(1 << $urandom_range(PIX_W-1));
            1: px.green ^= PIX_W'(1 << $urandom_range(PIX_W-1));
            default: px.blue ^= PIX_W'(1 << $urandom_range(PIX_W-1));
         endcase
      end else begin
         px.red   = PIX_W'($urandom);
         px.green = PIX_W'($urandom);
         px.blue  = PIX_W'($urandom);
      end
      px.tile_end = 1'b0;
      return px;
   endfunction

   task automatic push_random_tiles(input int items);
      pixel_t px;
      int     len;
      int     done;
      logic   all_keyed;
      done = 0;
      while (done < items) begin
         len = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         all_keyed = ($urandom_range(99) < 8);
         for (int i = 0; i < len; i++) begin
            px = random_pixel();
            if (all_keyed) begin
               px.red   = key_red_q;
               px.green = key_green_q;
               px.blue  = key_blue_q;
            end
            px.tile_end = (i == len - 1);
            pixel_queue.push_back(px);
         end
         done += len;
      end
      random_items += done;
   endtask

   // Waits until every pixel is taken and every mean has arrived, then lets
   // the divider settle.
   task automatic wait_for_idle();
      while (pixel_queue.size() != 0 || req_if.valid || mean_queue.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Reset key (magenta) first.
      push_pixel(0, 0, 0, 1'b1);
      push_pixel(255, 255, 255, 1'b1);
      push_pixel(255, 0, 255, 1'b1);
      push_pixel(255, 0, 255, 1'b0);
      push_pixel(255, 0, 255, 1'b0);
      push_pixel(255, 0, 255, 1'b1);
      push_pixel(255, 0, 254, 1'b0);
      push_pixel(254, 0, 255, 1'b0);
      push_pixel(255, 0, 255, 1'b0);
      push_pixel(10, 20, 30, 1'b1);
      push_pixel(254, 0, 255, 1'b0);
      push_pixel(255, 1, 255, 1'b0);
      push_pixel(255, 0, 254, 1'b1);
      // A keyed last pixel still closes the tile.
      push_pixel(100, 50, 3, 1'b0);
      push_pixel(101, 51, 4, 1'b0);
      push_pixel(255, 0, 255, 1'b1);
      push_pixel(1, 1, 1, 1'b0);
      push_pixel(2, 2, 2, 1'b1);
      push_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
      push_pixel(8'h55, 8'hAA, 8'hF0, 1'b1);
      wait_for_idle();

      push_random_tiles(100);
      wait_for_idle();

      set_key(8'd0, 8'd0, 8'd0, 1'b1);
      push_random_tiles(40);
      wait_for_idle();
      push_random_tiles(60);
      wait_for_idle();

      set_key(8'd255, 8'd255, 8'd255, 1'b1);
      calm = 1'b1;
      push_random_tiles(100);
      wait_for_idle();
      calm = 1'b0;

      // Keying off: magenta pixels are counted.
      set_key(8'd255, 8'd0, 8'd255, 1'b0);
      push_pixel(255, 0, 255, 1'b1);
      push_pixel(255, 0, 255, 1'b0);
      push_pixel(0, 0, 0, 1'b1);
      push_random_tiles(100);
      wait_for_idle();

      set_key(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b1);
      // Hold the receiver off so that finished tiles back up into the input.
      hold_request = 400;
      for (int i = 0; i < 15; i++)
         push_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), 1'b1);
      push_random_tiles(100);
      wait_for_idle();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
